// File: rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// Result width and the per-item classification flags.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

  localparam int ROOT_WIDTH = 40;

  typedef struct packed {
    logic degenerate;  // quadratic coefficient is zero
    logic no_real;     // discriminant below zero
    logic single;      // discriminant exactly zero
  } qrs_flags_t;

endpackage

`default_nettype wire

// File: rtl/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt: pipelined integer square root
// One result bit per stage, digit by digit, with a tag carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt #(
  parameter int SW = 33,
  parameter int TW = 35
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [2*SW-1:0]   rad,
  input  wire logic [TW-1:0]     tag_in,
  output logic                   out_valid,
  output logic [SW-1:0]          root,
  output logic [TW-1:0]          tag_out
);

  logic [SW:0]        v;
  logic [2*SW-1:0]    rad_q  [SW+1];
  logic [SW:0]        rem_q  [SW+1];
  logic [SW-1:0]      root_q [SW+1];
  logic [TW-1:0]      tag_q  [SW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      rad_q[0]  <= rad;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      tag_q[0]  <= tag_in;
    end
  end

  for (genvar k = 1; k <= SW; k++) begin : g_stage
    logic [SW+1:0] rem_sh;
    logic [SW+1:0] trial;
    logic          ge;

    always_comb begin
      rem_sh = {rem_q[k-1][SW-1:0], rad_q[k-1][2*SW-1 -: 2]};
      trial  = {root_q[k-1], 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
      if (en) begin
        rad_q[k]  <= rad_q[k-1] << 2;
        rem_q[k]  <= ge ? (SW+1)'(rem_sh - trial) : rem_sh[SW:0];
        root_q[k] <= {root_q[k-1][SW-2:0], ge};
        tag_q[k]  <= tag_q[k-1];
      end
    end
  end

  assign out_valid = v[SW];
  assign root      = root_q[SW];
  assign tag_out   = tag_q[SW];

endmodule

`default_nettype wire

// File: rtl/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div: two-lane pipelined restoring divider
// Divides two signed numerators by one shared signed divisor, one quotient
// bit per stage; returns magnitudes and result signs.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div #(
  parameter int NW   = 35,
  parameter int DENW = 17
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic signed [NW-1:0]    num_p,
  input  wire logic signed [NW-1:0]    num_m,
  input  wire logic signed [DENW-1:0]  den,
  input  wire qrs_pkg::qrs_flags_t     flags_in,
  output logic                         out_valid,
  output logic [1:0][NW-1:0]           quot,
  output logic [1:0]                   neg,
  output qrs_pkg::qrs_flags_t          flags_out
);
  import qrs_pkg::*;

  logic [NW:0]             v;
  logic [1:0][NW-1:0]      n_q   [NW+1];
  logic [1:0][DENW-1:0]    r_q   [NW+1];
  logic [1:0][NW-1:0]      q_q   [NW+1];
  logic [DENW-1:0]         ud_q  [NW+1];
  logic [1:0]              neg_q [NW+1];
  qrs_flags_t              fl_q  [NW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      n_q[0][0]  <= num_p[NW-1] ? -num_p : num_p;
      n_q[0][1]  <= num_m[NW-1] ? -num_m : num_m;
      r_q[0]     <= '0;
      q_q[0]     <= '0;
      ud_q[0]    <= den[DENW-1] ? -den : den;
      neg_q[0]   <= {num_m[NW-1] ^ den[DENW-1], num_p[NW-1] ^ den[DENW-1]};
      fl_q[0]    <= flags_in;
    end
  end

  for (genvar k = 1; k <= NW; k++) begin : g_stage
    logic [1:0][DENW:0]   r_sh;
    logic [1:0]           ge;

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        r_sh[l] = {r_q[k-1][l], n_q[k-1][l][NW-1]};
        ge[l]   = (r_sh[l] >= {1'b0, ud_q[k-1]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          n_q[k][l] <= n_q[k-1][l] << 1;
          r_q[k][l] <= ge[l] ? DENW'(r_sh[l] - {1'b0, ud_q[k-1]}) : r_sh[l][DENW-1:0];
          q_q[k][l] <= {q_q[k-1][l][NW-2:0], ge[l]};
        end
        ud_q[k]  <= ud_q[k-1];
        neg_q[k] <= neg_q[k-1];
        fl_q[k]  <= fl_q[k-1];
      end
    end
  end

  assign out_valid = v[NW];
  assign quot      = q_q[NW];
  assign neg       = neg_q[NW];
  assign flags_out = fl_q[NW];

endmodule

`default_nettype wire

// File: rtl/quadratic_real_root_solver_core.sv
// ----------------------------------------------------------------------------
// quadratic_real_root_solver_core: real roots of a*x^2 + b*x + c = 0
// Discriminant, pipelined square root and divider, saturation to Q23.16.
// ----------------------------------------------------------------------------
// Takes one coefficient set per cycle while in_ready is high and gives one
// result per set, in order. The pipeline is the input capture, products and
// discriminant registers, COEF_WIDTH+FRAC_BITS+2 square-root stages, one
// numerator stage, COEF_WIDTH+FRAC_BITS+4 divider stages and the output
// register. The whole pipeline holds while a result waits at the output, so
// throughput is one set per cycle when out_ready stays high. A zero quadratic
// coefficient flags degenerate with no roots.
`default_nettype none

module quadratic_real_root_solver_core #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic signed [COEF_WIDTH-1:0]            coef_a,
  input  wire logic signed [COEF_WIDTH-1:0]            coef_b,
  input  wire logic signed [COEF_WIDTH-1:0]            coef_c,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic [1:0]                                   root_count,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0]        root_plus,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0]        root_minus,
  output logic                                         degenerate
);
  import qrs_pkg::*;

  localparam int CW   = COEF_WIDTH;
  localparam int DW   = 2 * CW + 2;
  localparam int SW   = CW + FRAC_BITS + 1;
  localparam int NW   = CW + FRAC_BITS + 3;
  localparam int DENW = CW + 1;
  localparam int TW   = 2 * CW + 3;
  localparam int XW   = (NW > ROOT_WIDTH ? NW : ROOT_WIDTH) + 1;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // capture
  logic                 v0;
  logic signed [CW-1:0] a0, b0, c0;
  // products
  logic                   v1;
  logic signed [CW-1:0]   a1, b1;
  logic signed [2*CW-1:0] bb1, ac1;
  // discriminant
  logic                 v2;
  logic signed [CW-1:0] a2, b2;
  logic signed [DW-1:0] d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
    if (en) begin
      a0  <= coef_a;
      b0  <= coef_b;
      c0  <= coef_c;
      a1  <= a0;
      b1  <= b0;
      bb1 <= b0 * b0;
      ac1 <= a0 * c0;
      a2  <= a1;
      b2  <= b1;
      d2  <= DW'(bb1) - (DW'(ac1) <<< 2);
    end
  end

  qrs_flags_t           fl2;
  logic [2*SW-1:0]      rad2;
  logic                 sq_valid;
  logic [SW-1:0]        sq_root;
  logic [TW-1:0]        sq_tag;

  always_comb begin
    fl2.degenerate = (a2 == '0);
    fl2.no_real    = d2[DW-1];
    fl2.single     = (d2 == '0);
    rad2 = d2[DW-1] ? '0 : ((2*SW)'(d2[DW-2:0]) << (2 * FRAC_BITS));
  end

  qrs_sqrt #(.SW(SW), .TW(TW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .rad      (rad2),
    .tag_in   ({a2, b2, fl2}),
    .out_valid(sq_valid),
    .root     (sq_root),
    .tag_out  (sq_tag)
  );

  // numerators -b*2^F +/- s over divisor 2a
  logic signed [CW-1:0] a3s, b3s;
  logic signed [NW-1:0] nb3;
  logic                 v4;
  logic signed [NW-1:0] np4, nm4;
  logic signed [DENW-1:0] den4;
  qrs_flags_t           fl4;

  always_comb begin
    a3s = sq_tag[TW-1 -: CW];
    b3s = sq_tag[TW-CW-1 -: CW];
    nb3 = (-NW'(b3s)) <<< FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= sq_valid;
    end
    if (en) begin
      np4  <= nb3 + NW'(sq_root);
      nm4  <= nb3 - NW'(sq_root);
      den4 <= DENW'(a3s) <<< 1;
      fl4  <= sq_tag[2:0];
    end
  end

  logic               dv_valid;
  logic [1:0][NW-1:0] dv_quot;
  logic [1:0]         dv_neg;
  qrs_flags_t         dv_fl;

  qrs_div #(.NW(NW), .DENW(DENW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v4),
    .num_p    (np4),
    .num_m    (nm4),
    .den      (den4),
    .flags_in (fl4),
    .out_valid(dv_valid),
    .quot     (dv_quot),
    .neg      (dv_neg),
    .flags_out(dv_fl)
  );

  // saturate, apply sign, pick fields
  logic [1:0][ROOT_WIDTH-1:0] sat;
  logic [XW-1:0]              qx;
  logic [XW-1:0]              lim;
  logic [1:0]                 count_next;

  always_comb begin
    lim = XW'(1) << (ROOT_WIDTH - 1);
    for (int l = 0; l < 2; l++) begin
      qx = XW'(dv_quot[l]);
      if (dv_neg[l]) begin
        if (qx > lim) qx = lim;
        sat[l] = ROOT_WIDTH'(-qx);
      end else begin
        if (qx > lim - XW'(1)) qx = lim - XW'(1);
        sat[l] = ROOT_WIDTH'(qx);
      end
    end
    priority if (dv_fl.degenerate || dv_fl.no_real) count_next = 2'd0;
    else if (dv_fl.single)                          count_next = 2'd1;
    else                                            count_next = 2'd2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid;
    end
    if (en) begin
      root_count <= count_next;
      degenerate <= dv_fl.degenerate;
      root_plus  <= (count_next == 2'd0) ? '0 : sat[0];
      root_minus <= (count_next == 2'd2) ? sat[1] : '0;
    end
  end

  a_deg_no_roots: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> root_count == 2'd0)
    else $error("degenerate result reports roots");

  a_minus_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && root_count != 2'd2 |-> root_minus == '0)
    else $error("minus root set without two roots");

  a_plus_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && root_count == 2'd0 |-> root_plus == '0)
    else $error("plus root set without a root");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> $stable(root_count) && $stable(root_plus))
    else $error("output moved during stall");

endmodule

`default_nettype wire
